// ----- src/dmbms_pkg.sv -----
// ----------------------------------------------------------------------------
// dmbms_pkg
// Shared widths, scoring constants, register indexes and pipeline word types
// for the display mode best-match selector.
// ----------------------------------------------------------------------------
package dmbms_pkg;

  localparam int SIZE_W    = 14;
  localparam int REFRESH_W = 10;
  localparam int INDEX_W   = 6;
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int SCORE_W   = 33;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam int SCORE_EXACT    = 1000000;
  localparam int SCORE_NEAR     = 500000;
  localparam int REFRESH_WEIGHT = 100;

  // Weighted refresh difference stays below 2^17 (1023 * 100).
  localparam int RD_X_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PREF_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREF_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREF_REFRESH = 2'd2;

  // First stage word: squares and area of one mode.
  typedef struct packed {
    logic [SIZE_W-1:0]    w;
    logic [SIZE_W-1:0]    h;
    logic [REFRESH_W-1:0] r;
    logic                 last;
    logic                 pref_mode;
    logic                 exact;
    logic                 rnz;
    logic [REFRESH_W-1:0] rd;
    logic [AREA_W-1:0]    dw2;
    logic [AREA_W-1:0]    dh2;
    logic [AREA_W-1:0]    area;
    logic [SIZE_W-1:0]    pw;
    logic [SIZE_W-1:0]    ph;
  } sq_word_t;

  // Second stage word: finished score of one mode.
  typedef struct packed {
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [REFRESH_W-1:0]      r;
    logic                      last;
    logic                      pref_mode;
    logic [AREA_W-1:0]         area;
    logic [SIZE_W-1:0]         pw;
    logic [SIZE_W-1:0]         ph;
    logic signed [SCORE_W-1:0] score;
  } scored_t;

endpackage

// ----- src/dmbms_score.sv -----
// ----------------------------------------------------------------------------
// dmbms_score
// Two-stage scoring pipeline: squared size distance, area and refresh
// difference in the first stage, the preference score in the second.
// ----------------------------------------------------------------------------
module dmbms_score (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dmbms_pkg::SIZE_W-1:0]       mode_width,
  input  logic [dmbms_pkg::SIZE_W-1:0]       mode_height,
  input  logic [dmbms_pkg::REFRESH_W-1:0]    mode_refresh,
  input  logic                               is_last,
  input  logic [dmbms_pkg::SIZE_W-1:0]       pref_width,
  input  logic [dmbms_pkg::SIZE_W-1:0]       pref_height,
  input  logic [dmbms_pkg::REFRESH_W-1:0]    pref_refresh,
  output logic                               item_valid,
  input  logic                               item_ready,
  output dmbms_pkg::scored_t                 item
);

  localparam int SW = dmbms_pkg::SCORE_W;

  logic                   p1_v_r, p1_v_nxt;
  logic                   p2_v_r, p2_v_nxt;
  dmbms_pkg::sq_word_t    p1_r, p1_nxt;
  dmbms_pkg::scored_t     p2_r, p2_nxt;
  logic                   ld1, ld2, p2_free;

  logic [dmbms_pkg::SIZE_W-1:0]    adw, adh;
  logic [dmbms_pkg::RD_X_W-1:0]    rd_x;
  logic [SW-1:0]                   score_u;

  assign p2_free  = !p2_v_r || item_ready;
  assign ld2      = p1_v_r && p2_free;
  assign in_ready = !p1_v_r || p2_free;
  assign ld1      = in_valid && in_ready;

  // Stage 1: distances, squares and area.
  always_comb begin
    adw = (mode_width > pref_width) ? mode_width - pref_width : pref_width - mode_width;
    adh = (mode_height > pref_height) ? mode_height - pref_height
                                      : pref_height - mode_height;
    p1_nxt.w         = mode_width;
    p1_nxt.h         = mode_height;
    p1_nxt.r         = mode_refresh;
    p1_nxt.last      = is_last;
    p1_nxt.pref_mode = (pref_width != '0) && (pref_height != '0);
    p1_nxt.exact     = (mode_width == pref_width) && (mode_height == pref_height);
    p1_nxt.rnz       = (pref_refresh != '0);
    p1_nxt.rd        = (mode_refresh > pref_refresh) ? mode_refresh - pref_refresh
                                                     : pref_refresh - mode_refresh;
    p1_nxt.dw2       = dmbms_pkg::AREA_W'(adw) * dmbms_pkg::AREA_W'(adw);
    p1_nxt.dh2       = dmbms_pkg::AREA_W'(adh) * dmbms_pkg::AREA_W'(adh);
    p1_nxt.area      = dmbms_pkg::AREA_W'(mode_width) * dmbms_pkg::AREA_W'(mode_height);
    p1_nxt.pw        = pref_width;
    p1_nxt.ph        = pref_height;
  end

  // Stage 2: fold into one signed score.
  always_comb begin
    rd_x = dmbms_pkg::RD_X_W'(p1_r.rd) *
           dmbms_pkg::RD_X_W'(dmbms_pkg::REFRESH_WEIGHT);
    if (p1_r.exact) begin
      if (p1_r.rnz) begin
        score_u = SW'(dmbms_pkg::SCORE_EXACT) - SW'(rd_x);
      end else begin
        score_u = SW'(dmbms_pkg::SCORE_EXACT) + SW'(p1_r.r);
      end
    end else begin
      score_u = SW'(dmbms_pkg::SCORE_NEAR) - SW'(p1_r.dw2) - SW'(p1_r.dh2)
              - (p1_r.rnz ? SW'(p1_r.rd) : '0);
    end
    p2_nxt.w         = p1_r.w;
    p2_nxt.h         = p1_r.h;
    p2_nxt.r         = p1_r.r;
    p2_nxt.last      = p1_r.last;
    p2_nxt.pref_mode = p1_r.pref_mode;
    p2_nxt.area      = p1_r.area;
    p2_nxt.pw        = p1_r.pw;
    p2_nxt.ph        = p1_r.ph;
    p2_nxt.score     = $signed(score_u);
  end

  always_comb begin
    p1_v_nxt = in_ready ? in_valid : p1_v_r;
    p2_v_nxt = p2_free ? p1_v_r : p2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= p1_v_nxt;
      p2_v_r <= p2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      p1_r <= p1_nxt;
    end
    if (ld2) begin
      p2_r <= p2_nxt;
    end
  end

  assign item_valid = p2_v_r;
  assign item       = p2_r;

endmodule

// ----- src/dmbms_track.sv -----
// ----------------------------------------------------------------------------
// dmbms_track
// Running best mode of the current list and the result register that
// reports it after the last mode.
// ----------------------------------------------------------------------------
module dmbms_track #(
  parameter int MAX_MODES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  dmbms_pkg::scored_t                 item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dmbms_pkg::INDEX_W-1:0]      best_index,
  output logic [dmbms_pkg::SIZE_W-1:0]       best_width,
  output logic [dmbms_pkg::SIZE_W-1:0]       best_height,
  output logic [dmbms_pkg::REFRESH_W-1:0]    best_refresh,
  output logic                               exact_match
);

  localparam int CNT_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int EXT_W = CNT_W + dmbms_pkg::INDEX_W;

  logic signed [dmbms_pkg::SCORE_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]                     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                     ch_idx_r, ch_idx_nxt;
  logic [dmbms_pkg::SIZE_W-1:0]         ch_w_r, ch_w_nxt;
  logic [dmbms_pkg::SIZE_W-1:0]         ch_h_r, ch_h_nxt;
  logic [dmbms_pkg::REFRESH_W-1:0]      ch_r_r, ch_r_nxt;
  logic [dmbms_pkg::AREA_W-1:0]         ch_area_r, ch_area_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [dmbms_pkg::INDEX_W-1:0]        o_idx_r;
  logic [dmbms_pkg::SIZE_W-1:0]         o_w_r, o_h_r;
  logic [dmbms_pkg::REFRESH_W-1:0]      o_r_r;
  logic                                 o_exact_r;
  logic [EXT_W-1:0]                     idx_ext;

  logic fire, report, first, better, nonpref_win, take_mode;

  // A non-last word never needs the result register.
  assign item_ready = !item.last || !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;
  assign report     = fire && item.last;

  always_comb begin
    first       = (cnt_r == '0);
    better      = (item.score > best_r);
    nonpref_win = (item.r > ch_r_r) || ((item.r == ch_r_r) && (item.area > ch_area_r));
    take_mode   = first || (item.pref_mode ? better : nonpref_win);

    best_nxt    = best_r;
    cnt_nxt     = cnt_r;
    ch_idx_nxt  = ch_idx_r;
    ch_w_nxt    = ch_w_r;
    ch_h_nxt    = ch_h_r;
    ch_r_nxt    = ch_r_r;
    ch_area_nxt = ch_area_r;

    if (fire) begin
      if (item.pref_mode && better) begin
        best_nxt = item.score;
      end
      if (take_mode) begin
        ch_idx_nxt  = cnt_r;
        ch_w_nxt    = item.w;
        ch_h_nxt    = item.h;
        ch_r_nxt    = item.r;
        ch_area_nxt = item.area;
      end
      // Saturate the position counter at the last slot.
      if (cnt_r < CNT_W'(MAX_MODES - 1)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (item.last) begin
        best_nxt = '1;  // minus one
        cnt_nxt  = '0;
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (report) begin
      out_valid_nxt = 1'b1;
    end

    idx_ext = EXT_W'(ch_idx_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '1;
      cnt_r       <= '0;
      ch_idx_r    <= '0;
      ch_w_r      <= '0;
      ch_h_r      <= '0;
      ch_r_r      <= '0;
      ch_area_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      best_r      <= best_nxt;
      cnt_r       <= cnt_nxt;
      ch_idx_r    <= ch_idx_nxt;
      ch_w_r      <= ch_w_nxt;
      ch_h_r      <= ch_h_nxt;
      ch_r_r      <= ch_r_nxt;
      ch_area_r   <= ch_area_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      o_idx_r   <= idx_ext[dmbms_pkg::INDEX_W-1:0];
      o_w_r     <= ch_w_nxt;
      o_h_r     <= ch_h_nxt;
      o_r_r     <= ch_r_nxt;
      o_exact_r <= item.pref_mode && (ch_w_nxt == item.pw) && (ch_h_nxt == item.ph);
    end
  end

  assign out_valid    = out_valid_r;
  assign best_index   = o_idx_r;
  assign best_width   = o_w_r;
  assign best_height  = o_h_r;
  assign best_refresh = o_r_r;
  assign exact_match  = o_exact_r;

endmodule

// ----- src/display_mode_best_match_selector.sv -----
// ----------------------------------------------------------------------------
// display_mode_best_match_selector
// Picks the best display mode of a list, by preference score or by highest
// refresh and area, and reports it after the last mode of the list.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------------------
//  in_     | input     | in_valid/in_ready  | width, height, refresh, is_last
//  out_    | output    | out_valid/out_ready| index, size, refresh, exact
//  cfg_    | input     | cfg_we             | pref width/height/refresh
//
//  One mode per cycle while in_ready is high. A list's result word passes the
//  squares register, loaded as the mode is taken, then the score register,
//  and the tracker then loads the result into the output register.
//  Reset clears the pipeline valids and index counter; running best goes to -1.
//  in_ready falls only when a last word reaches the tracker while the output
//  register still holds an untaken word and both pipeline stages are full.
// ----------------------------------------------------------------------------
module display_mode_best_match_selector #(
  parameter int MAX_MODES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dmbms_pkg::SIZE_W-1:0]       in_mode_width,
  input  logic [dmbms_pkg::SIZE_W-1:0]       in_mode_height,
  input  logic [dmbms_pkg::REFRESH_W-1:0]    in_mode_refresh,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dmbms_pkg::INDEX_W-1:0]      out_best_index,
  output logic [dmbms_pkg::SIZE_W-1:0]       out_best_width,
  output logic [dmbms_pkg::SIZE_W-1:0]       out_best_height,
  output logic [dmbms_pkg::REFRESH_W-1:0]    out_best_refresh,
  output logic                               out_exact_match,
  input  logic                               cfg_we,
  input  logic [dmbms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmbms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [dmbms_pkg::SIZE_W-1:0]    pref_w_r, pref_w_nxt;
  logic [dmbms_pkg::SIZE_W-1:0]    pref_h_r, pref_h_nxt;
  logic [dmbms_pkg::REFRESH_W-1:0] pref_r_r, pref_r_nxt;

  logic               item_valid, item_ready;
  dmbms_pkg::scored_t item;

  always_comb begin
    pref_w_nxt = pref_w_r;
    pref_h_nxt = pref_h_r;
    pref_r_nxt = pref_r_r;
    if (cfg_we) begin
      case (cfg_index)
        dmbms_pkg::REG_PREF_WIDTH:   pref_w_nxt = cfg_wdata;
        dmbms_pkg::REG_PREF_HEIGHT:  pref_h_nxt = cfg_wdata;
        dmbms_pkg::REG_PREF_REFRESH: pref_r_nxt = cfg_wdata[dmbms_pkg::REFRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_w_r <= '0;
      pref_h_r <= '0;
      pref_r_r <= '0;
    end else begin
      pref_w_r <= pref_w_nxt;
      pref_h_r <= pref_h_nxt;
      pref_r_r <= pref_r_nxt;
    end
  end

  dmbms_score u_score (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode_width   (in_mode_width),
    .mode_height  (in_mode_height),
    .mode_refresh (in_mode_refresh),
    .is_last      (in_is_last),
    .pref_width   (pref_w_r),
    .pref_height  (pref_h_r),
    .pref_refresh (pref_r_r),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item)
  );

  dmbms_track #(
    .MAX_MODES (MAX_MODES)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .best_index   (out_best_index),
    .best_width   (out_best_width),
    .best_height  (out_best_height),
    .best_refresh (out_best_refresh),
    .exact_match  (out_exact_match)
  );

endmodule

// ----- src/dmbms_checker.sv -----
// ----------------------------------------------------------------------------
// dmbms_checker
// Port-level checks of the best-match selector, bound to the top level.
// ----------------------------------------------------------------------------
module dmbms_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [dmbms_pkg::INDEX_W-1:0]      out_best_index,
  input logic [dmbms_pkg::SIZE_W-1:0]       out_best_width,
  input logic [dmbms_pkg::SIZE_W-1:0]       out_best_height,
  input logic [dmbms_pkg::REFRESH_W-1:0]    out_best_refresh,
  input logic                               out_exact_match
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_index) &&
      $stable(out_best_width) && $stable(out_best_height) &&
      $stable(out_best_refresh) && $stable(out_exact_match))
    else $error("result word changed while stalled");

  // Reset drops the result channel.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the output register empty, a new mode is always taken.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // An exact match only happens against a nonzero preferred size.
  a_exact_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exact_match |-> out_best_width != '0 && out_best_height != '0)
    else $error("exact match on zero size");

endmodule

bind display_mode_best_match_selector dmbms_checker u_dmbms_checker (.*);
